// ===== hdl/pftr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pftr_pkg: shared types and arithmetic for the pixel format converter
// Holds the source format codes, the output pixel type and the BT.601
// integer conversion used for the packed 4:2:2 formats.
// ----------------------------------------------------------------------------
package pftr_pkg;

  typedef enum logic [2:0] {
    FMT_RGB8  = 3'd0,
    FMT_BGR8  = 3'd1,
    FMT_RGBA8 = 3'd2,
    FMT_BGRA8 = 3'd3,
    FMT_Y8    = 3'd4,
    FMT_Y16   = 3'd5,
    FMT_YUYV  = 3'd6,
    FMT_UYVY  = 3'd7
  } src_format_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  localparam logic [7:0] AlphaOpaque = 8'hFF;
  localparam logic [7:0] ChromaFlip  = 8'h80;

  // Wide enough for the largest BT.601 sum, about 137000, plus sign.
  localparam int unsigned SumW = 20;

  localparam logic signed [SumW-1:0] LumaOfs = SumW'(16);
  localparam logic signed [SumW-1:0] KLuma   = SumW'(298);
  localparam logic signed [SumW-1:0] KRedV   = SumW'(409);
  localparam logic signed [SumW-1:0] KGreenU = SumW'(100);
  localparam logic signed [SumW-1:0] KGreenV = SumW'(208);
  localparam logic signed [SumW-1:0] KBlueU  = SumW'(516);
  localparam logic signed [SumW-1:0] Round   = SumW'(128);

  // Floor shift by eight, then clamp to 0..255.
  function automatic logic [7:0] sat_shift(logic signed [SumW-1:0] s);
    logic [7:0] res;
    if (s[SumW-1]) begin
      res = 8'h00;
    end else if (|s[SumW-2:16]) begin
      res = 8'hFF;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  // One pixel from a luma byte and the centered chroma pair.
  function automatic pixel_t yuv_to_pixel(logic [7:0] y, logic signed [7:0] d,
                                          logic signed [7:0] e);
    logic signed [SumW-1:0] c;
    logic signed [SumW-1:0] dx;
    logic signed [SumW-1:0] ex;
    logic signed [SumW-1:0] luma;
    pixel_t px;
    c    = $signed({{(SumW-8){1'b0}}, y}) - LumaOfs;
    dx   = SumW'(d);
    ex   = SumW'(e);
    luma = KLuma * c + Round;
    px.red   = sat_shift(luma + KRedV * ex);
    px.green = sat_shift(luma - KGreenU * dx - KGreenV * ex);
    px.blue  = sat_shift(luma + KBlueU * dx);
    px.alpha = AlphaOpaque;
    return px;
  endfunction

endpackage

// ===== hdl/pixel_format_to_rgbx.sv =====
`timescale 1ns / 1ps
// A word accepted into the input register moves to the result register once
// that stage can advance, from where the receiver takes it. One word per cycle
// while the receiver keeps ready high; the input and result registers form a
// two-stage pipeline whose ready is forwarded from the output side.
// Reset clears both valid flags and sets the source format to RGB8.
// Payload registers are not reset.
// ----------------------------------------------------------------------------
// pixel_format_to_rgbx: camera pixel to RGBX8888 converter
// Four source bytes per word become one display pixel, or two for the
// packed YUV 4:2:2 formats, as selected by the source format register.
// ----------------------------------------------------------------------------
module pixel_format_to_rgbx (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration: source format register.
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_wdata_i,
  // Input words.
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] src_byte0_i,
  input  logic [7:0] src_byte1_i,
  input  logic [7:0] src_byte2_i,
  input  logic [7:0] src_byte3_i,
  // Result words.
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] first_red_o,
  output logic [7:0] first_green_o,
  output logic [7:0] first_blue_o,
  output logic [7:0] first_alpha_o,
  output logic [7:0] second_red_o,
  output logic [7:0] second_green_o,
  output logic [7:0] second_blue_o,
  output logic [7:0] second_alpha_o,
  output logic       second_valid_o
);
  import pftr_pkg::*;

  src_format_e fmt_q;

  // Stage one holds the raw source bytes.
  logic       s1_valid_q;
  logic [7:0] b0_q, b1_q, b2_q, b3_q;

  // Stage two is the result register driving the outputs.
  logic   out_valid_q;
  pixel_t first_q, first_d;
  pixel_t second_q, second_d;
  logic   second_valid_q, second_valid_d;

  logic s2_ready;
  logic s1_ready;

  // Each stage advances when it is empty or the stage after it drains.
  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RGB8;
    end else if (cfg_we_i) begin
      fmt_q <= src_format_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      b0_q <= src_byte0_i;
      b1_q <= src_byte1_i;
      b2_q <= src_byte2_i;
      b3_q <= src_byte3_i;
    end
  end

  // Conversion. The chroma bytes are centered by flipping their top bit,
  // which is the same as subtracting 128 into a signed byte. Both pixels of
  // a macropixel share the chroma pair and differ only in luma.
  logic [7:0]        y1, y2, u, v;
  logic signed [7:0] d, e;
  pixel_t            yuv1, yuv2;

  always_comb begin
    if (fmt_q == FMT_YUYV) begin
      y1 = b0_q;
      u  = b1_q;
      y2 = b2_q;
      v  = b3_q;
    end else begin
      u  = b0_q;
      y1 = b1_q;
      v  = b2_q;
      y2 = b3_q;
    end
    d    = $signed(u ^ ChromaFlip);
    e    = $signed(v ^ ChromaFlip);
    yuv1 = yuv_to_pixel(y1, d, e);
    yuv2 = yuv_to_pixel(y2, d, e);
  end

  always_comb begin
    first_d        = '{red: b0_q, green: b1_q, blue: b2_q, alpha: AlphaOpaque};
    second_d       = '0;
    second_valid_d = 1'b0;
    unique case (fmt_q) inside
      FMT_RGB8: begin
        first_d = '{red: b0_q, green: b1_q, blue: b2_q, alpha: AlphaOpaque};
      end
      FMT_BGR8: begin
        first_d = '{red: b2_q, green: b1_q, blue: b0_q, alpha: AlphaOpaque};
      end
      FMT_RGBA8: begin
        first_d = '{red: b0_q, green: b1_q, blue: b2_q, alpha: b3_q};
      end
      FMT_BGRA8: begin
        first_d = '{red: b2_q, green: b1_q, blue: b0_q, alpha: b3_q};
      end
      FMT_Y8: begin
        first_d = '{red: b0_q, green: b0_q, blue: b0_q, alpha: AlphaOpaque};
      end
      FMT_Y16: begin
        // Little-endian 16-bit luma: the high byte comes second.
        first_d = '{red: b1_q, green: b1_q, blue: b1_q, alpha: AlphaOpaque};
      end
      FMT_YUYV, FMT_UYVY: begin
        first_d        = yuv1;
        second_d       = yuv2;
        second_valid_d = 1'b1;
      end
      default: begin
        first_d = '{red: b0_q, green: b1_q, blue: b2_q, alpha: AlphaOpaque};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      first_q        <= first_d;
      second_q       <= second_d;
      second_valid_q <= second_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_red_o    = first_q.red;
  assign first_green_o  = first_q.green;
  assign first_blue_o   = first_q.blue;
  assign first_alpha_o  = first_q.alpha;
  assign second_red_o   = second_q.red;
  assign second_green_o = second_q.green;
  assign second_blue_o  = second_q.blue;
  assign second_alpha_o = second_q.alpha;
  assign second_valid_o = second_valid_q;

  // A two-pixel result is always opaque in both pixels.
  a_yuv_opaque: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && second_valid_q |->
      first_q.alpha == AlphaOpaque && second_q.alpha == AlphaOpaque)
    else $error("YUV result with non-opaque alpha");

  // A single-pixel result leaves the second pixel at zero.
  a_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !second_valid_q |-> second_q == '0)
    else $error("second pixel not cleared for single-pixel word");

  // The input stage never takes a word while it is full and cannot drain.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !(s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stage overrun");

  // A stalled input stage keeps its word.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=>
      s1_valid_q && $stable(b0_q) && $stable(b1_q) && $stable(b2_q) && $stable(b3_q))
    else $error("input stage lost a stalled word");

endmodule

// ===== tb/pixel_format_to_rgbx_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_to_rgbx_tb: self-checking bench for the pixel format converter
// Sends source words through the valid/ready input channel under every source
// format. Each accepted word is converted by a behavioral model of the
// format rules and the BT.601 math. Each result word is checked field by
// field against the oldest pending prediction. Both channels idle at random,
// and one long receiver hold-off backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module pixel_format_to_rgbx_tb;

  import pftr_pkg::*;

  // One source word as it sits on the input channel.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } src_word_t;

  // What one accepted word should turn into.
  typedef struct packed {
    pixel_t first;
    pixel_t second;
    logic   pair;
  } rgbx_result_t;

  localparam int ClkHalf     = 5;
  localparam int HoldCycles  = 300;
  // The slowest correct run is roughly 900 words, each waiting out the longest
  // sender gap and the longest receiver stall, plus phase changes and the
  // hold-off; the limit allows about five times that.
  localparam int CycleLimit  = 600000;
  localparam int RandPhases  = 12;
  localparam int PhaseWords  = 70;
  localparam int MaxPrinted  = 30;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       cfg_we_i       = 1'b0;
  logic [2:0] cfg_wdata_i    = 3'd0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [7:0] src_byte0_i    = 8'd0;
  logic [7:0] src_byte1_i    = 8'd0;
  logic [7:0] src_byte2_i    = 8'd0;
  logic [7:0] src_byte3_i    = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] first_red_o;
  logic [7:0] first_green_o;
  logic [7:0] first_blue_o;
  logic [7:0] first_alpha_o;
  logic [7:0] second_red_o;
  logic [7:0] second_green_o;
  logic [7:0] second_blue_o;
  logic [7:0] second_alpha_o;
  logic       second_valid_o;

  pixel_format_to_rgbx uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .src_byte0_i    (src_byte0_i),
    .src_byte1_i    (src_byte1_i),
    .src_byte2_i    (src_byte2_i),
    .src_byte3_i    (src_byte3_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_red_o    (first_red_o),
    .first_green_o  (first_green_o),
    .first_blue_o   (first_blue_o),
    .first_alpha_o  (first_alpha_o),
    .second_red_o   (second_red_o),
    .second_green_o (second_green_o),
    .second_blue_o  (second_blue_o),
    .second_alpha_o (second_alpha_o),
    .second_valid_o (second_valid_o)
  );

  // Words waiting to be sent, and the converted pixels still owed by the block.
  src_word_t    word_q[$];
  rgbx_result_t pixel_q[$];

  // The format the bench believes is loaded; it changes only while idle.
  src_format_e  fmt_model = FMT_RGB8;

  bit           idle_on   = 1'b1;
  bit           hold_req  = 1'b0;
  bit           hold_done = 1'b0;
  logic         holding   = 1'b0;
  int           hold_cnt  = 0;

  int           send_gap  = 0;
  int           recv_gap  = 0;
  logic         send_fire;
  logic         send_next;
  logic         recv_next;
  src_word_t    next_word;
  rgbx_result_t want_px;

  int           sent_cnt     = 0;
  int           checked_cnt  = 0;
  int           mismatch_cnt = 0;
  int           cfg_writes   = 0;
  int           pair_cnt     = 0;
  int           cycle_cnt    = 0;

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral model of the conversion
  // --------------------------------------------------------------------------

  // Floor shift by eight and clamp to a byte. A negative sum always gives 0.
  function automatic logic [7:0] clamp_scaled(int sum);
    int v;
    if (sum < 0) begin
      return 8'h00;
    end
    v = sum >>> 8;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  // BT.601 integer conversion of one luma sample with its shared chroma.
  // The chroma arguments arrive already centered on zero.
  function automatic pixel_t bt601_pixel(int luma, int cb, int cr);
    int     c;
    pixel_t px;
    c        = luma - 16;
    px.red   = clamp_scaled(298 * c + 409 * cr + 128);
    px.green = clamp_scaled(298 * c - 100 * cb - 208 * cr + 128);
    px.blue  = clamp_scaled(298 * c + 516 * cb + 128);
    px.alpha = 8'hFF;
    return px;
  endfunction

  function automatic rgbx_result_t predict_rgbx(src_format_e fmt, src_word_t w);
    rgbx_result_t r;
    int           y1;
    int           y2;
    int           u;
    int           v;
    // Single-pixel formats leave the second pixel all zero and flagged off.
    r             = '0;
    r.first.alpha = 8'hFF;
    case (fmt)
      FMT_RGB8: begin
        r.first.red = w.b0; r.first.green = w.b1; r.first.blue = w.b2;
      end
      FMT_BGR8: begin
        r.first.red = w.b2; r.first.green = w.b1; r.first.blue = w.b0;
      end
      FMT_RGBA8: begin
        r.first.red = w.b0; r.first.green = w.b1; r.first.blue = w.b2;
        r.first.alpha = w.b3;
      end
      FMT_BGRA8: begin
        r.first.red = w.b2; r.first.green = w.b1; r.first.blue = w.b0;
        r.first.alpha = w.b3;
      end
      FMT_Y8: begin
        r.first.red = w.b0; r.first.green = w.b0; r.first.blue = w.b0;
      end
      FMT_Y16: begin
        // High byte of a little-endian sample.
        r.first.red = w.b1; r.first.green = w.b1; r.first.blue = w.b1;
      end
      default: begin
        if (fmt == FMT_YUYV) begin
          y1 = w.b0; u = w.b1; y2 = w.b2; v = w.b3;
        end else begin
          u = w.b0; y1 = w.b1; v = w.b2; y2 = w.b3;
        end
        r.first  = bt601_pixel(y1, u - 128, v - 128);
        r.second = bt601_pixel(y2, u - 128, v - 128);
        r.pair   = 1'b1;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers shared by the driver, the monitor and the stimulus
  // --------------------------------------------------------------------------

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Byte values with the corners of the YUV math weighted up.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return ($urandom_range(0, 1) != 0) ? 8'd16 : 8'd235;
      3:       return ($urandom_range(0, 1) != 0) ? 8'd128 : 8'd240;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted) begin
      $display("[%0t] mismatch at result %0d: %s is %0d, expected %0d",
               $realtime, checked_cnt, what, got, want);
    end
  endtask

  // Queue pushes happen at the falling edge so they never race the driver.
  task automatic push_word(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                           logic [7:0] b3);
    src_word_t w;
    w.b0 = b0; w.b1 = b1; w.b2 = b2; w.b3 = b3;
    word_q.push_back(w);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (word_q.size() != 0 || in_valid_i || pixel_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // The block must be idle when the format changes; the extra cycles cover
  // the two-stage pipeline in case a word is still on its way out.
  task automatic set_format(src_format_e f);
    wait_drained();
    repeat (4) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
    fmt_model = f;
    cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers one word at a time from word_q, with random gaps between
  // words. A word stays on the bus unchanged until the block takes it, and the
  // prediction is made at that same edge with the format then loaded.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      send_fire = in_valid_i && in_ready_o;
      if (send_fire) begin
        next_word.b0 = src_byte0_i;
        next_word.b1 = src_byte1_i;
        next_word.b2 = src_byte2_i;
        next_word.b3 = src_byte3_i;
        pixel_q.push_back(predict_rgbx(fmt_model, next_word));
        sent_cnt++;
      end
      if (!in_valid_i || send_fire) begin
        send_next = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (word_q.size() != 0) begin
          next_word   = word_q.pop_front();
          src_byte0_i <= next_word.b0;
          src_byte1_i <= next_word.b1;
          src_byte2_i <= next_word.b2;
          src_byte3_i <= next_word.b3;
          send_next   = 1'b1;
          send_gap    = pick_gap();
        end
        in_valid_i <= send_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off: once requested, ready is held low while hold_cnt
  // counts up to HoldCycles and the driver keeps offering words, so the pipeline fills and
  // the block has to push back on its input.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      holding <= 1'b0;
      hold_cnt = 0;
    end else if (hold_req && !hold_done) begin
      if (!holding) begin
        holding <= 1'b1;
        hold_cnt = 0;
      end else if (hold_cnt == HoldCycles) begin
        holding <= 1'b0;
        hold_done = 1'b1;
      end else begin
        hold_cnt++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: randomly stalls the result channel, and checks every result word
  // it takes against the oldest pending prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("result word with nothing pending", 1, 0);
        end else begin
          want_px = pixel_q.pop_front();
          checked_cnt++;
          if (want_px.pair) pair_cnt++;
          if (first_red_o !== want_px.first.red)
            report_mismatch("first_red", first_red_o, want_px.first.red);
          if (first_green_o !== want_px.first.green)
            report_mismatch("first_green", first_green_o, want_px.first.green);
          if (first_blue_o !== want_px.first.blue)
            report_mismatch("first_blue", first_blue_o, want_px.first.blue);
          if (first_alpha_o !== want_px.first.alpha)
            report_mismatch("first_alpha", first_alpha_o, want_px.first.alpha);
          if (second_red_o !== want_px.second.red)
            report_mismatch("second_red", second_red_o, want_px.second.red);
          if (second_green_o !== want_px.second.green)
            report_mismatch("second_green", second_green_o, want_px.second.green);
          if (second_blue_o !== want_px.second.blue)
            report_mismatch("second_blue", second_blue_o, want_px.second.blue);
          if (second_alpha_o !== want_px.second.alpha)
            report_mismatch("second_alpha", second_alpha_o, want_px.second.alpha);
          if (second_valid_o !== want_px.pair)
            report_mismatch("second_valid", second_valid_o, want_px.pair);
        end
      end
      recv_next = 1'b0;
      if (recv_gap > 0) begin
        recv_gap--;
      end else begin
        recv_next = 1'b1;
        recv_gap  = pick_gap();
      end
      out_ready_i <= recv_next && !holding;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still pending",
             cycle_cnt, pixel_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed corner words under every format, then random phases.
  // --------------------------------------------------------------------------
  initial begin
    src_format_e f;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The first words go out under the reset format, which must be RGB8.
    push_word(8'h00, 8'h00, 8'h00, 8'h00);
    push_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_word(8'h01, 8'h80, 8'hFE, 8'h7F);

    // Plain formats: all bits low, then all bits high.
    for (int k = int'(FMT_BGR8); k <= int'(FMT_Y16); k++) begin
      set_format(src_format_e'(k));
      push_word(8'h00, 8'h00, 8'h00, 8'h00);
      push_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    end

    // Packed YUV: both rails, a neutral black, and a word where red clamps
    // high on one pixel while blue goes negative and clamps to zero on the other.
    set_format(FMT_YUYV);
    push_word(8'h00, 8'h00, 8'h00, 8'h00);
    push_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_word(8'd16, 8'd128, 8'd16, 8'd128);
    push_word(8'd235, 8'd16, 8'd81, 8'd240);
    set_format(FMT_UYVY);
    push_word(8'h00, 8'h00, 8'h00, 8'h00);
    push_word(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_word(8'd128, 8'd16, 8'd128, 8'd16);
    push_word(8'd16, 8'd235, 8'd240, 8'd81);

    // Random phases. The first two pin the format extremes; one phase runs
    // with no idling on either side, and one carries the long hold-off.
    for (int p = 0; p < RandPhases; p++) begin
      if (p == 0) begin
        f = FMT_UYVY;
      end else if (p == 1) begin
        f = FMT_RGB8;
      end else begin
        f = src_format_e'($urandom_range(0, 7));
      end
      set_format(f);
      idle_on = (p != 5);
      if (p == 3) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PhaseWords; n++) begin
        push_word(pick_byte(), pick_byte(), pick_byte(), pick_byte());
      end
    end

    wait_drained();
    repeat (8) @(negedge clk_i);

    $display("Sent %0d words over %0d format writes; %0d results checked, %0d of them pairs.",
             sent_cnt, cfg_writes, checked_cnt, pair_cnt);
    $display("Mismatches: %0d, results left pending: %0d.", mismatch_cnt, pixel_q.size());
    if (mismatch_cnt == 0 && pixel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
